// ===== hdl/dncd_pkg.sv =====
// Shared types, widths and tables for the day number to calendar date block.
// No dependencies.
package dncd_pkg;

    localparam int IN_W  = 48;
    localparam int YR_W  = 25;
    localparam int Y_W   = 26;
    localparam int J_W   = 34;
    localparam int TW_W  = 36;
    localparam int MO_W  = 4;
    localparam int DY_W  = 7;
    localparam int OFS_W = 9;

    typedef enum logic [4:0] {
        ST_IDLE, ST_YEST,
        ST_Y_UP, ST_Y_UP_W, ST_Y_DN, ST_Y_DN_W,
        ST_M_UP, ST_M_UP_W, ST_M_DN, ST_M_DN_W,
        ST_D_UP, ST_D_UP_W, ST_D_DN, ST_D_DN_W,
        ST_T_HR, ST_T_MIN, ST_T_SEC, ST_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_YR_EST,
        OP_YR_NEXT, OP_YR_CUR, OP_YR_INC, OP_YR_DEC,
        OP_MO_EST, OP_MO_NEXT, OP_MO_PREV,
        OP_DY_EST, OP_DY_NEXT, OP_DY_PREV,
        OP_HR, OP_MIN, OP_SEC, OP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic pass;
        logic out_busy;
    } t_dp_sts;

    // days before the first of each month, non-leap
    function automatic logic [OFS_W-1:0] month_offset(input logic [MO_W-1:0] m);
        logic [OFS_W-1:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd59;
            4'd3:    r = 9'd90;
            4'd4:    r = 9'd120;
            4'd5:    r = 9'd151;
            4'd6:    r = 9'd181;
            4'd7:    r = 9'd212;
            4'd8:    r = 9'd243;
            4'd9:    r = 9'd273;
            4'd10:   r = 9'd304;
            4'd11:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/dncd_conv.sv =====
// Forward conversion (year, month, day) to twice the day count, four stages.
// Depends on dncd_pkg.
module dncd_conv (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [dncd_pkg::YR_W-1:0]   i_yr,
    input  logic        [dncd_pkg::MO_W-1:0]   i_mo,
    input  logic        [dncd_pkg::DY_W-1:0]   i_dy,
    output logic                               o_done,
    output logic signed [dncd_pkg::TW_W-1:0]   o_tw
);

    localparam int J_W  = dncd_pkg::J_W;
    localparam int TW_W = dncd_pkg::TW_W;
    localparam int Y_W  = dncd_pkg::Y_W;
    localparam int MO_W = dncd_pkg::MO_W;

    localparam logic signed [J_W-1:0] GREG_LIMIT = J_W'(2361232);
    localparam logic signed [J_W-1:0] BASE_A     = J_W'(1794167);
    localparam logic signed [J_W-1:0] BASE_B     = J_W'(1721117);
    localparam logic [38:0]           D1         = 39'd3652422;
    localparam logic [32:0]           D2         = 33'd146100;
    localparam logic [16:0]           M1         = 17'((64'd100 << 32) / 64'd3652422);
    localparam logic [14:0]           M2         = 15'((64'd1 << 32) / 64'd146100);
    localparam logic signed [TW_W-1:0] TWICE_EPOCH = TW_W'(4830041);

    logic [4:0] r_vld;

    logic signed [dncd_pkg::YR_W-1:0] r_yr;
    logic [MO_W-1:0]                  r_mo;
    logic [dncd_pkg::DY_W-1:0]        r_dy;

    logic signed [J_W-1:0] r_j1, r_j2, r_j3;
    logic                  r_g2, r_g3;
    logic [31:0]           r_x1, r_x2;
    logic [16:0]           r_q1e, r_q1e3;
    logic [14:0]           r_q2e, r_q2e3;
    logic                  r_ge1, r_ge2;
    logic signed [TW_W-1:0] r_tw;

    // stage 1: Julian count
    logic                   s1_carry;
    logic signed [Y_W-1:0]  s1_y0, s1_y1, s1_y;
    logic [MO_W-1:0]        s1_m;
    logic                   s1_leap;
    logic signed [J_W-1:0]  s1_yj, s1_base, s1_quad, s1_add, s1_j;

    always_comb begin
        s1_carry = (r_mo > 4'd12);
        s1_y0    = Y_W'(r_yr) + Y_W'(s1_carry);
        s1_m     = r_mo - 4'd1 - (s1_carry ? 4'd12 : 4'd0);
        s1_y1    = (s1_y0 < 0) ? s1_y0 + Y_W'(1) : s1_y0;
        s1_y     = s1_y1 + Y_W'(4712);
        s1_leap  = (s1_y[1:0] == 2'b00) && (s1_m > 4'd1);
        s1_yj    = J_W'(s1_y);
        s1_base  = s1_yj * J_W'(365);
        s1_quad  = (s1_yj + J_W'(3)) >>> 2;
        s1_add   = J_W'(dncd_pkg::month_offset(s1_m)) + J_W'(r_dy) + J_W'(s1_leap) - J_W'(1);
        s1_j     = s1_base + s1_quad + s1_add;
    end

    // stage 2: quotient estimates by reciprocal
    logic [31:0] s2_x1, s2_x2;
    logic [48:0] s2_p1;
    logic [46:0] s2_p2;

    always_comb begin
        s2_x1 = 32'(r_j1 - BASE_A);
        s2_x2 = 32'(r_j1 - BASE_B);
        s2_p1 = 49'(s2_x1) * 49'(M1);
        s2_p2 = 47'(s2_x2) * 47'(M2);
    end

    // stage 3: remainder checks
    logic [38:0] s3_n1, s3_t1, s3_r1;
    logic [32:0] s3_t2, s3_r2;

    always_comb begin
        s3_n1 = 39'(r_x1) * 39'd100;
        s3_t1 = 39'(r_q1e) * D1;
        s3_r1 = s3_n1 - s3_t1;
        s3_t2 = 33'(r_q2e) * D2;
        s3_r2 = 33'(r_x2) - s3_t2;
    end

    // stage 4: correction and scaling
    logic [16:0]           s4_q1;
    logic [14:0]           s4_q2;
    logic signed [J_W-1:0] s4_corr, s4_j;

    always_comb begin
        s4_q1   = r_q1e3 + 17'(r_ge1);
        s4_q2   = r_q2e3 + 15'(r_ge2);
        s4_corr = J_W'(s4_q1) - J_W'(s4_q2);
        s4_j    = r_g3 ? r_j3 - s4_corr : r_j3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_yr <= i_yr;
            r_mo <= i_mo;
            r_dy <= i_dy;
        end
        r_j1   <= s1_j;
        r_j2   <= r_j1;
        r_g2   <= (r_j1 > GREG_LIMIT);
        r_x1   <= s2_x1;
        r_x2   <= s2_x2;
        r_q1e  <= s2_p1[48:32];
        r_q2e  <= s2_p2[46:32];
        r_j3   <= r_j2;
        r_g3   <= r_g2;
        r_q1e3 <= r_q1e;
        r_q2e3 <= r_q2e;
        r_ge1  <= (s3_r1 >= D1);
        r_ge2  <= (s3_r2 >= D2);
        if (r_vld[3]) begin
            r_tw <= (TW_W'(s4_j) <<< 1) - TWICE_EPOCH;
        end
    end

    assign o_done = r_vld[4];
    assign o_tw   = r_tw;

endmodule

// ===== hdl/dncd_datapath.sv =====
// Datapath: input word, field registers, estimates, time of day, output register.
// Depends on dncd_pkg and dncd_conv.
module dncd_datapath #(
    parameter int FRAC_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dncd_pkg::t_dp_cmd                 i_cmd,
    output dncd_pkg::t_dp_sts                 o_sts,
    input  logic signed [dncd_pkg::IN_W-1:0]  i_day_number,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic signed [15:0]                o_year,
    output logic [3:0]                        o_month,
    output logic [4:0]                        o_day,
    output logic [4:0]                        o_hour,
    output logic [5:0]                        o_minute,
    output logic [5:0]                        o_second
);

    localparam int IN_W = dncd_pkg::IN_W;
    localparam int YR_W = dncd_pkg::YR_W;
    localparam int MO_W = dncd_pkg::MO_W;
    localparam int DY_W = dncd_pkg::DY_W;
    localparam int DI_W = IN_W - FRAC_BITS;
    localparam int YP_W = DI_W + 25;
    localparam int TP_W = FRAC_BITS + 17;
    localparam logic signed [24:0] YEAR_K = 25'((64'd10000 << 32) / 64'd3652422);

    logic signed [IN_W-1:0] r_d;
    logic signed [YR_W-1:0] r_yr;
    logic [MO_W-1:0]        r_mo;
    logic [DY_W-1:0]        r_dy;
    logic [4:0]             r_hr;
    logic [10:0]            r_mins;
    logic [16:0]            r_secs;
    logic                   r_valid;

    logic signed [YR_W-1:0] c_yr;
    logic [MO_W-1:0]        c_mo;
    logic [DY_W-1:0]        c_dy;
    logic                   c_start;
    logic                   conv_done;
    logic signed [dncd_pkg::TW_W-1:0] conv_tw;

    always_comb begin
        c_yr    = r_yr;
        c_mo    = 4'd1;
        c_dy    = DY_W'(1);
        c_start = 1'b0;
        case (i_cmd.op)
            dncd_pkg::OP_YR_NEXT: begin
                c_yr    = r_yr + YR_W'(1);
                c_start = 1'b1;
            end
            dncd_pkg::OP_YR_CUR: begin
                c_start = 1'b1;
            end
            dncd_pkg::OP_MO_NEXT: begin
                c_mo    = r_mo + 4'd1;
                c_start = 1'b1;
            end
            dncd_pkg::OP_MO_PREV: begin
                c_mo    = r_mo - 4'd1;
                c_start = 1'b1;
            end
            dncd_pkg::OP_DY_NEXT: begin
                c_mo    = r_mo;
                c_dy    = r_dy + DY_W'(1);
                c_start = 1'b1;
            end
            dncd_pkg::OP_DY_PREV: begin
                c_mo    = r_mo;
                c_dy    = r_dy - DY_W'(1);
                c_start = 1'b1;
            end
            default: begin
                c_start = 1'b0;
            end
        endcase
    end

    dncd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_yr    (c_yr),
        .i_mo    (c_mo),
        .i_dy    (c_dy),
        .o_done  (conv_done),
        .o_tw    (conv_tw)
    );

    // compare and distance against the last conversion
    logic signed [IN_W-1:0] dh, tw_ext, gap, days;
    logic                   pass;

    always_comb begin
        dh     = r_d >>> (FRAC_BITS - 1);
        tw_ext = IN_W'(conv_tw);
        pass   = (dh >= tw_ext);
        gap    = dh - tw_ext;
        days   = gap >>> 1;
    end

    // year estimate
    logic signed [DI_W-1:0] dint;
    logic signed [YP_W-1:0] yprod;
    logic signed [YR_W-1:0] yest;

    always_comb begin
        dint  = DI_W'(r_d >>> FRAC_BITS);
        yprod = YP_W'(dint) * YP_W'(YEAR_K);
        yest  = YR_W'(yprod >>> 32) + YR_W'(1900);
    end

    // month and day estimates
    logic [20:0]     mprod;
    logic [MO_W-1:0] mest;
    logic [DY_W-1:0] dest;

    always_comb begin
        mprod = 21'(days[8:0]) * 21'd2185;
        mest  = (days >= IN_W'(330)) ? 4'd12 : 4'd1 + MO_W'(mprod[20:16]);
        dest  = (days > IN_W'(62)) ? DY_W'(63) : DY_W'(1) + DY_W'(days[5:0]);
    end

    // time of day
    logic [FRAC_BITS-1:0] frac;
    logic [16:0]          tk;
    logic [TP_W-1:0]      tprod;
    logic [16:0]          tres;
    logic [10:0]          hr60;
    logic [16:0]          mn60;
    logic signed [15:0]   ysat;

    always_comb begin
        frac = {r_d[FRAC_BITS-1] ^ conv_tw[0], r_d[FRAC_BITS-2:0]};
        case (i_cmd.op)
            dncd_pkg::OP_HR:  tk = 17'd24;
            dncd_pkg::OP_MIN: tk = 17'd1440;
            default:          tk = 17'd86400;
        endcase
        tprod = TP_W'(frac) * TP_W'(tk);
        tres  = tprod[FRAC_BITS +: 17];
        hr60  = 11'(r_hr) * 11'd60;
        mn60  = 17'(r_mins) * 17'd60;
        if (r_yr > YR_W'(32767)) begin
            ysat = 16'sh7fff;
        end else if (r_yr < -YR_W'(32768)) begin
            ysat = -16'sh8000;
        end else begin
            ysat = 16'(r_yr);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            dncd_pkg::OP_LOAD:    r_d    <= i_day_number;
            dncd_pkg::OP_YR_EST:  r_yr   <= yest;
            dncd_pkg::OP_YR_INC:  r_yr   <= r_yr + YR_W'(1);
            dncd_pkg::OP_YR_DEC:  r_yr   <= r_yr - YR_W'(1);
            dncd_pkg::OP_MO_EST:  r_mo   <= mest;
            dncd_pkg::OP_MO_NEXT: r_mo   <= c_mo;
            dncd_pkg::OP_MO_PREV: r_mo   <= c_mo;
            dncd_pkg::OP_DY_EST:  r_dy   <= dest;
            dncd_pkg::OP_DY_NEXT: r_dy   <= c_dy;
            dncd_pkg::OP_DY_PREV: r_dy   <= c_dy;
            dncd_pkg::OP_HR:      r_hr   <= tres[4:0];
            dncd_pkg::OP_MIN:     r_mins <= tres[10:0];
            dncd_pkg::OP_SEC:     r_secs <= tres;
            default: begin
            end
        endcase
        if (i_cmd.op == dncd_pkg::OP_FIN) begin
            o_year   <= ysat;
            o_month  <= r_mo;
            o_day    <= r_dy[4:0];
            o_hour   <= r_hr;
            o_minute <= 6'(r_mins - hr60);
            o_second <= 6'(r_secs - mn60);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == dncd_pkg::OP_FIN) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_sts.conv_done = conv_done;
    assign o_sts.pass      = pass;
    assign o_sts.out_busy  = r_valid && !i_ready;

endmodule

// ===== hdl/dncd_ctrl.sv =====
// Controller: sequences the year, month and day searches and the time of day.
// Depends on dncd_pkg.
module dncd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  dncd_pkg::t_dp_sts i_sts,
    output dncd_pkg::t_dp_cmd o_cmd
);

    dncd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dncd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = dncd_pkg::OP_NONE;
        case (r_state)
            dncd_pkg::ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = dncd_pkg::OP_LOAD;
                    n_state  = dncd_pkg::ST_YEST;
                end
            end
            dncd_pkg::ST_YEST: begin
                o_cmd.op = dncd_pkg::OP_YR_EST;
                n_state  = dncd_pkg::ST_Y_UP;
            end
            dncd_pkg::ST_Y_UP: begin
                o_cmd.op = dncd_pkg::OP_YR_NEXT;
                n_state  = dncd_pkg::ST_Y_UP_W;
            end
            dncd_pkg::ST_Y_UP_W: begin
                if (i_sts.conv_done) begin
                    if (i_sts.pass) begin
                        o_cmd.op = dncd_pkg::OP_YR_INC;
                        n_state  = dncd_pkg::ST_Y_UP;
                    end else begin
                        n_state  = dncd_pkg::ST_Y_DN;
                    end
                end
            end
            dncd_pkg::ST_Y_DN: begin
                o_cmd.op = dncd_pkg::OP_YR_CUR;
                n_state  = dncd_pkg::ST_Y_DN_W;
            end
            dncd_pkg::ST_Y_DN_W: begin
                if (i_sts.conv_done) begin
                    if (!i_sts.pass) begin
                        o_cmd.op = dncd_pkg::OP_YR_DEC;
                        n_state  = dncd_pkg::ST_Y_DN;
                    end else begin
                        o_cmd.op = dncd_pkg::OP_MO_EST;
                        n_state  = dncd_pkg::ST_M_UP;
                    end
                end
            end
            dncd_pkg::ST_M_UP: begin
                o_cmd.op = dncd_pkg::OP_MO_NEXT;
                n_state  = dncd_pkg::ST_M_UP_W;
            end
            dncd_pkg::ST_M_UP_W: begin
                if (i_sts.conv_done) begin
                    n_state = i_sts.pass ? dncd_pkg::ST_M_UP : dncd_pkg::ST_M_DN;
                end
            end
            dncd_pkg::ST_M_DN: begin
                o_cmd.op = dncd_pkg::OP_MO_PREV;
                n_state  = dncd_pkg::ST_M_DN_W;
            end
            dncd_pkg::ST_M_DN_W: begin
                if (i_sts.conv_done) begin
                    if (!i_sts.pass) begin
                        n_state  = dncd_pkg::ST_M_DN;
                    end else begin
                        o_cmd.op = dncd_pkg::OP_DY_EST;
                        n_state  = dncd_pkg::ST_D_UP;
                    end
                end
            end
            dncd_pkg::ST_D_UP: begin
                o_cmd.op = dncd_pkg::OP_DY_NEXT;
                n_state  = dncd_pkg::ST_D_UP_W;
            end
            dncd_pkg::ST_D_UP_W: begin
                if (i_sts.conv_done) begin
                    n_state = i_sts.pass ? dncd_pkg::ST_D_UP : dncd_pkg::ST_D_DN;
                end
            end
            dncd_pkg::ST_D_DN: begin
                o_cmd.op = dncd_pkg::OP_DY_PREV;
                n_state  = dncd_pkg::ST_D_DN_W;
            end
            dncd_pkg::ST_D_DN_W: begin
                if (i_sts.conv_done) begin
                    n_state = i_sts.pass ? dncd_pkg::ST_T_HR : dncd_pkg::ST_D_DN;
                end
            end
            dncd_pkg::ST_T_HR: begin
                o_cmd.op = dncd_pkg::OP_HR;
                n_state  = dncd_pkg::ST_T_MIN;
            end
            dncd_pkg::ST_T_MIN: begin
                o_cmd.op = dncd_pkg::OP_MIN;
                n_state  = dncd_pkg::ST_T_SEC;
            end
            dncd_pkg::ST_T_SEC: begin
                o_cmd.op = dncd_pkg::OP_SEC;
                n_state  = dncd_pkg::ST_FIN;
            end
            dncd_pkg::ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = dncd_pkg::OP_FIN;
                    n_state  = dncd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dncd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == dncd_pkg::ST_IDLE);

endmodule

// ===== hdl/day_number_to_calendar_date.sv =====
// Day number to calendar date (GMT), top level.
// Depends on dncd_pkg, dncd_ctrl, dncd_datapath.
//
// Input channel: i_valid/o_ready carry one signed fixed-point day count
// (FRAC_BITS fraction bits, 0.5 is 1900 Jan 1 0h). Output channel:
// o_valid/i_ready carry year, month, day, hour, minute and second.
// One word is in work at a time. Each candidate year, month or day is
// tested through the date-to-count conversion pipeline, and the controller
// waits for its answer before it issues the next; a word takes longer the
// more candidates are tested, so longer for years far from the estimate.
// The result sits in an output register; the next word is accepted while
// it waits. If the receiver stalls, the finished next result holds in the
// controller until the register is free.
// Reset (synchronous, active low) idles the controller, empties the output
// register and clears the conversion valid bits; no other state is cleared.
module day_number_to_calendar_date #(
    parameter int FRAC_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [dncd_pkg::IN_W-1:0]  i_day_number,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [15:0]                o_year,
    output logic [3:0]                        o_month,
    output logic [4:0]                        o_day,
    output logic [4:0]                        o_hour,
    output logic [5:0]                        o_minute,
    output logic [5:0]                        o_second
);

    dncd_pkg::t_dp_cmd cmd;
    dncd_pkg::t_dp_sts sts;

    dncd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dncd_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_day_number (i_day_number),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

endmodule

// ===== bench/tb_day_number_to_calendar_date.sv =====
`timescale 1ns / 100ps
// Testbench for day_number_to_calendar_date: directed and random day counts, checked
// field by field against a calendar predictor held in a small scoreboard class.
// Depends on dncd_pkg and the RTL of the block.
module tb_day_number_to_calendar_date;

    localparam int  FRAC_BITS  = 24;
    localparam int  N_RANDOM   = 680;
    localparam int  CYCLE_CAP  = 600000;
    localparam int  HOLD_LEN   = 400;
    localparam int  QUIET_LO   = 300;
    localparam int  QUIET_HI   = 420;

    typedef struct {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
    } t_date;

    class calendar_board;
        t_date  dates_due[$];
        int     n_errors;
        int     n_checked;

        static function longint fdiv(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q = q - 1;
            return q;
        endfunction

        static function longint month_start(longint m);
            case (m)
                1:  return 31;
                2:  return 59;
                3:  return 90;
                4:  return 120;
                5:  return 151;
                6:  return 181;
                7:  return 212;
                8:  return 243;
                9:  return 273;
                10: return 304;
                11: return 334;
                default: return 0;
            endcase
        endfunction

        // Julian count with Gregorian correction
        static function longint julian_count(longint yr, longint mo, longint dy);
            longint carry, y, m, j, d;
            carry = fdiv(mo - 1, 12);
            y = yr + carry;
            m = mo - 1 - 12 * carry;
            d = dy;
            if (y < 0)
                y = y + 1;
            y = y + 4712;
            if (y[1:0] == 2'b00 && m > 1)
                d = d + 1;
            j = y * 365 + fdiv(y + 3, 4) + month_start(m) + d - 1;
            if (j > 2361232)
                j = j - (fdiv((j - 1794167) * 100, 3652422) - fdiv(j - 1721117, 146100));
            return j;
        endfunction

        static function longint day_count(longint yr, longint mo, longint dy);
            return (2 * julian_count(yr, mo, dy) - 4830041) * (longint'(1) << (FRAC_BITS - 1));
        endfunction

        static function t_date calendar_of(longint d);
            longint one, yr, mo, dy, frac, mins, hrs;
            t_date  r;
            one = longint'(1) << FRAC_BITS;
            yr = 1900 + fdiv(fdiv(d, one) * 10000, 3652422);
            while (day_count(yr + 1, 1, 1) <= d)
                yr++;
            while (day_count(yr, 1, 1) > d)
                yr--;
            mo = 1 + (d - day_count(yr, 1, 1)) / (longint'(30) << FRAC_BITS);
            do mo++; while (d >= day_count(yr, mo, 1));
            do mo--; while (d < day_count(yr, mo, 1));
            dy = 1 + ((d - day_count(yr, mo, 1)) >> FRAC_BITS);
            do dy++; while (d >= day_count(yr, mo, dy));
            do dy--; while (d < day_count(yr, mo, dy));
            frac = (d - day_count(yr, mo, dy)) & (one - 1);
            hrs  = (frac * 24) >> FRAC_BITS;
            mins = (frac * 1440) >> FRAC_BITS;
            if (yr > 32767)
                yr = 32767;
            if (yr < -32768)
                yr = -32768;
            r.year   = yr[15:0];
            r.month  = mo[3:0];
            r.day    = dy[4:0];
            r.hour   = hrs[4:0];
            r.minute = 6'(mins - 60 * hrs);
            r.second = 6'(((frac * 86400) >> FRAC_BITS) - 60 * mins);
            return r;
        endfunction

        function void note_word(logic signed [47:0] dn);
            longint d;
            d = dn;
            dates_due.push_back(calendar_of(d));
        endfunction

        function void check_word(t_date got);
            t_date want;
            n_checked++;
            if (dates_due.size() == 0) begin
                $display("%0t: result with nothing due: %0d-%0d-%0d", $time,
                         got.year, got.month, got.day);
                n_errors++;
                return;
            end
            want = dates_due.pop_front();
            if (got.year !== want.year) begin
                $display("%0t: year exp %0d got %0d", $time, want.year, got.year);
                n_errors++;
            end
            if (got.month !== want.month) begin
                $display("%0t: month exp %0d got %0d", $time, want.month, got.month);
                n_errors++;
            end
            if (got.day !== want.day) begin
                $display("%0t: day exp %0d got %0d", $time, want.day, got.day);
                n_errors++;
            end
            if (got.hour !== want.hour) begin
                $display("%0t: hour exp %0d got %0d", $time, want.hour, got.hour);
                n_errors++;
            end
            if (got.minute !== want.minute) begin
                $display("%0t: minute exp %0d got %0d", $time, want.minute, got.minute);
                n_errors++;
            end
            if (got.second !== want.second) begin
                $display("%0t: second exp %0d got %0d", $time, want.second, got.second);
                n_errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [47:0] i_day_number;
    logic               o_valid;
    logic               i_ready;
    logic signed [15:0] o_year;
    logic [3:0]         o_month;
    logic [4:0]         o_day;
    logic [4:0]         o_hour;
    logic [5:0]         o_minute;
    logic [5:0]         o_second;

    calendar_board board;
    int  n_sent;
    int  cycle_no;
    bit  hold_done;

    day_number_to_calendar_date #(.FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_day_number (i_day_number),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit quiet_stretch();
        return n_sent >= QUIET_LO && n_sent < QUIET_HI;
    endfunction

    task automatic send_word(input logic signed [47:0] dn);
        if (!quiet_stretch() && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (!quiet_stretch() && $urandom_range(99) < 34);
        end
        i_valid      <= 1'b1;
        i_day_number <= dn;
        do @(posedge i_clk); while (!o_ready);
        board.note_word(dn);
        n_sent++;
    endtask

    task automatic send_date(input longint yr, input longint mo, input longint dy,
                             input longint ofs);
        longint v;
        v = calendar_board::day_count(yr, mo, dy) + ofs;
        send_word(v[47:0]);
    endtask

    // receiver, with one long hold-off once the sender has got going
    initial begin
        t_date got;
        i_ready   = 1'b0;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && n_sent >= 200) begin
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_done = 1'b1;
            end
            i_ready <= quiet_stretch() ? 1'b1 : ($urandom_range(99) >= 34);
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                got.year   = o_year;
                got.month  = o_month;
                got.day    = o_day;
                got.hour   = o_hour;
                got.minute = o_minute;
                got.second = o_second;
                board.check_word(got);
            end
        end
    end

    initial begin
        cycle_no = 0;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (cycle_no > CYCLE_CAP) begin
                $display("timeout at cycle %0d", cycle_no);
                $display("day_number_to_calendar_date verification failed");
                $finish;
            end
        end
    end

    initial begin
        longint one, v;
        logic [63:0] r64;
        int  kind;
        board   = new();
        n_sent  = 0;
        one     = longint'(1) << FRAC_BITS;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_day_number = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_word(48'sd0);
        send_word(48'(one / 2));
        send_word(-48'sd1);
        send_word(48'(-(one / 2)));
        send_word(48'h7FFF_FFFF_FFFF);
        send_word(48'h8000_0000_0000);
        send_date(1900, 1, 1, 0);
        send_date(1900, 1, 1, -1);
        send_date(0, 1, 1, 0);
        send_date(0, 1, 1, -1);
        send_date(1, 1, 1, -1);
        send_date(-5, 3, 1, one / 3);
        send_date(1752, 9, 2, one - 1);
        send_date(1752, 9, 3, 0);
        send_date(1752, 9, 13, 0);
        send_date(1752, 9, 14, 0);
        v = (2 * longint'(2361232) - 4830041) * (one / 2);
        send_word(v[47:0]);
        send_word(48'(v - 1));
        send_date(2000, 2, 29, one / 2);
        send_date(1900, 3, 1, -1);
        send_date(2024, 12, 31, one - 1);
        send_date(1582, 10, 15, 0);

        // random
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 450) begin
                i_valid <= 1'b0;
                while (board.dates_due.size() != 0) @(posedge i_clk);
            end
            kind = $urandom_range(99);
            if (kind < 55)
                send_date(longint'($urandom_range(5000)) - 2500, $urandom_range(12, 1),
                          $urandom_range(31, 1), $urandom_range(one - 1));
            else if (kind < 75) begin
                r64 = {$urandom, $urandom};
                send_word(r64[47:0]);
            end else if (kind < 90)
                send_date(longint'($urandom_range(6000)) - 3000, $urandom_range(12, 1), 1,
                          longint'($urandom_range(1)) - 1);
            else
                send_date(longint'($urandom_range(44000)) - 21000, $urandom_range(12, 1),
                          $urandom_range(28, 1), $urandom_range(one - 1));
        end
        i_valid <= 1'b0;

        while (board.dates_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d day counts (extremes, calendar switch, BC years, random dates);",
                 n_sent);
        $display("checked %0d dates, with a long receiver hold-off and a full drain.",
                 board.n_checked);
        if (board.n_errors == 0 && board.dates_due.size() == 0)
            $display("day_number_to_calendar_date verification clean");
        else
            $display("day_number_to_calendar_date verification failed");
        $finish;
    end

endmodule
